FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/pt2pl_pkg.sv
// ----------------------------------------------------------------------------
// pt2pl_pkg
// Types and constants of the point to plane distance core.
// ----------------------------------------------------------------------------
package pt2pl_pkg;

   localparam int OUT_BITS       = 22;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FIRST_POINT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SECOND_POINT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THIRD_POINT  = 2'd2;

   // per-word control that travels with the data
   typedef struct packed {
      logic valid;
      logic neg;
      logic degen;
   } ctl_type;

endpackage

FILE: rtl/point_to_plane_distance_core.sv
// ----------------------------------------------------------------------------
// point_to_plane_distance_core
// Signed distance of a query point to the plane through three points.
// Throughput: one word per cycle; busy is always low.
// Depth is set by the square-root/divide, one result bit per stage.
// Reset clears the plane registers and all pipeline valid bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_to_plane_distance_core #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_BITS-1:0]           req_query_x,
   input  logic signed [COORD_BITS-1:0]           req_query_y,
   input  logic signed [COORD_BITS-1:0]           req_query_z,
   output logic                                   rsp_strobe,
   output logic signed [pt2pl_pkg::OUT_BITS-1:0]  rsp_signed_distance,
   output logic                                   rsp_degenerate,
   input  logic                                   csr_write_enable,
   input  logic [pt2pl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [3*COORD_BITS-1:0]                csr_write_data
);

   localparam int OB   = pt2pl_pkg::OUT_BITS;
   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * DW;
   localparam int CW   = PW + 1;
   localparam int NW   = CW + DW + 2;
   localparam int N2W  = 2 * CW + 2;
   localparam int LO   = (NW + 1) / 2;
   localparam int HI   = NW - LO;
   localparam int PQW  = OB + N2W;
   localparam int RW   = 2 * NW + 2 * FRAC_BITS;
   localparam int TW   = ((RW > 2 * OB + N2W) ? RW : 2 * OB + N2W) + 2;

   logic [3*COORD_BITS-1:0] p1_ff, p2_ff, p3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
         p2_ff <= '0;
         p3_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pt2pl_pkg::REG_FIRST_POINT:  p1_ff <= csr_write_data;
            pt2pl_pkg::REG_SECOND_POINT: p2_ff <= csr_write_data;
            pt2pl_pkg::REG_THIRD_POINT:  p3_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic signed [COORD_BITS-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
   assign x1 = p1_ff[COORD_BITS-1:0];
   assign y1 = p1_ff[2*COORD_BITS-1:COORD_BITS];
   assign z1 = p1_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign x2 = p2_ff[COORD_BITS-1:0];
   assign y2 = p2_ff[2*COORD_BITS-1:COORD_BITS];
   assign z2 = p2_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign x3 = p3_ff[COORD_BITS-1:0];
   assign y3 = p3_ff[2*COORD_BITS-1:COORD_BITS];
   assign z3 = p3_ff[3*COORD_BITS-1:2*COORD_BITS];

   // stage 1: differences against the first point
   logic                 v1_ff;
   logic signed [DW-1:0] ux1_ff, uy1_ff, uz1_ff, vx1_ff, vy1_ff, vz1_ff;
   logic signed [DW-1:0] qx1_ff, qy1_ff, qz1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      ux1_ff <= DW'(x2) - DW'(x1);
      uy1_ff <= DW'(y2) - DW'(y1);
      uz1_ff <= DW'(z2) - DW'(z1);
      vx1_ff <= DW'(x3) - DW'(x1);
      vy1_ff <= DW'(y3) - DW'(y1);
      vz1_ff <= DW'(z3) - DW'(z1);
      qx1_ff <= DW'(req_query_x) - DW'(x1);
      qy1_ff <= DW'(req_query_y) - DW'(y1);
      qz1_ff <= DW'(req_query_z) - DW'(z1);
   end

   // stage 2: cross product terms
   logic                 v2_ff;
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [DW-1:0] qx2_ff, qy2_ff, qz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      m0_ff  <= uy1_ff * vz1_ff;
      m1_ff  <= uz1_ff * vy1_ff;
      m2_ff  <= uz1_ff * vx1_ff;
      m3_ff  <= ux1_ff * vz1_ff;
      m4_ff  <= ux1_ff * vy1_ff;
      m5_ff  <= uy1_ff * vx1_ff;
      qx2_ff <= qx1_ff;
      qy2_ff <= qy1_ff;
      qz2_ff <= qz1_ff;
   end

   // stage 3: normal
   logic                 v3_ff;
   logic signed [CW-1:0] a3_ff, b3_ff, c3_ff;
   logic signed [DW-1:0] qx3_ff, qy3_ff, qz3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      a3_ff  <= CW'(m0_ff) - CW'(m1_ff);
      b3_ff  <= CW'(m2_ff) - CW'(m3_ff);
      c3_ff  <= CW'(m4_ff) - CW'(m5_ff);
      qx3_ff <= qx2_ff;
      qy3_ff <= qy2_ff;
      qz3_ff <= qz2_ff;
   end

   // stage 4: dot product terms and squared normal terms
   logic                      v4_ff, dg4_ff;
   logic signed [CW+DW-1:0]   ax4_ff, by4_ff, cz4_ff;
   logic signed [2*CW-1:0]    aa4_ff, bb4_ff, cc4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      dg4_ff <= (a3_ff == '0) && (b3_ff == '0) && (c3_ff == '0);
      ax4_ff <= a3_ff * qx3_ff;
      by4_ff <= b3_ff * qy3_ff;
      cz4_ff <= c3_ff * qz3_ff;
      aa4_ff <= a3_ff * a3_ff;
      bb4_ff <= b3_ff * b3_ff;
      cc4_ff <= c3_ff * c3_ff;
   end

   // stage 5: sums
   logic                 v5_ff, dg5_ff;
   logic signed [NW-1:0] num5_ff;
   logic [N2W-1:0]       n25_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      dg5_ff  <= dg4_ff;
      num5_ff <= NW'(ax4_ff) + NW'(by4_ff) + NW'(cz4_ff);
      n25_ff  <= N2W'(unsigned'(aa4_ff)) + N2W'(unsigned'(bb4_ff))
               + N2W'(unsigned'(cc4_ff));
   end

   // stage 6: partial products of the squared numerator
   logic [NW-1:0]        mag5;
   logic [HI-1:0]        mhi;
   logic [LO-1:0]        mlo;
   pt2pl_pkg::ctl_type   c6_ff;
   logic [2*HI-1:0]      hh6_ff;
   logic [HI+LO-1:0]     hl6_ff;
   logic [2*LO-1:0]      ll6_ff;
   logic [N2W-1:0]       n26_ff;

   assign mag5 = num5_ff[NW-1] ? NW'(-num5_ff) : NW'(num5_ff);
   assign mhi  = mag5[NW-1:LO];
   assign mlo  = mag5[LO-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         c6_ff.valid <= 1'b0;
      end else begin
         c6_ff.valid <= v5_ff;
      end
      c6_ff.neg   <= num5_ff[NW-1];
      c6_ff.degen <= dg5_ff;
      hh6_ff      <= mhi * mhi;
      hl6_ff      <= mhi * mlo;
      ll6_ff      <= mlo * mlo;
      n26_ff      <= n25_ff;
   end

   // bit-serial root/divide: stage i settles result bit OB-1-i
   pt2pl_pkg::ctl_type ctl_ff [0:OB];
   logic [TW-1:0]      r_ff   [0:OB];
   logic [TW-1:0]      t_ff   [0:OB];
   logic [PQW-1:0]     p_ff   [0:OB];
   logic [N2W-1:0]     n2_ff  [0:OB];
   logic [OB-1:0]      q_ff   [0:OB];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= c6_ff.valid;
      end
      ctl_ff[0].neg   <= c6_ff.neg;
      ctl_ff[0].degen <= c6_ff.degen;
      r_ff[0]  <= ((TW'(hh6_ff) << (2 * LO)) + (TW'(hl6_ff) << (LO + 1)) + TW'(ll6_ff))
                  << (2 * FRAC_BITS);
      t_ff[0]  <= '0;
      p_ff[0]  <= '0;
      n2_ff[0] <= n26_ff;
      q_ff[0]  <= '0;
   end

   for (genvar i = 0; i < OB; i++) begin : g_root
      localparam int K = OB - 1 - i;
      logic [TW-1:0] trial_t;
      logic          cap_ok;
      logic          take;

      assign trial_t = t_ff[i] + (TW'(p_ff[i]) << (K + 1)) + (TW'(n2_ff[i]) << (2 * K));
      if (K == OB - 1) begin : g_top
         assign cap_ok = ctl_ff[i].neg;
      end else begin : g_rest
         assign cap_ok = !q_ff[i][OB-1];
      end
      assign take = cap_ok && (trial_t <= r_ff[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i+1].valid <= 1'b0;
         end else begin
            ctl_ff[i+1].valid <= ctl_ff[i].valid;
         end
         ctl_ff[i+1].neg   <= ctl_ff[i].neg;
         ctl_ff[i+1].degen <= ctl_ff[i].degen;
         r_ff[i+1]  <= r_ff[i];
         n2_ff[i+1] <= n2_ff[i];
         t_ff[i+1]  <= take ? trial_t : t_ff[i];
         p_ff[i+1]  <= take ? p_ff[i] + (PQW'(n2_ff[i]) << K) : p_ff[i];
         q_ff[i+1]  <= take ? (q_ff[i] | (OB'(1) << K)) : q_ff[i];
      end
   end

   // output word
   logic                 rsp_strobe_ff;
   logic signed [OB-1:0] rsp_dist_ff;
   logic                 rsp_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl_ff[OB].valid;
      end
      rsp_degen_ff <= ctl_ff[OB].degen;
      if (ctl_ff[OB].degen) begin
         rsp_dist_ff <= '0;
      end else if (ctl_ff[OB].neg) begin
         rsp_dist_ff <= -q_ff[OB];
      end else begin
         rsp_dist_ff <= q_ff[OB];
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_signed_distance = rsp_dist_ff;
   assign rsp_degenerate      = rsp_degen_ff;

   `ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_strobe_ff && rsp_degen_ff, rsp_dist_ff == '0)
   `ASSERT_IMPLY(a_pos_cap, clock, reset, ctl_ff[OB].valid && !ctl_ff[OB].neg, !q_ff[OB][OB-1])
   `ASSERT_NEXT(a_strobe_follows, clock, reset, ctl_ff[OB].valid, rsp_strobe_ff)

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_to_plane_distance_core. It loads plane points
// over the csr port and streams query words. A directed table with pinned
// values comes first, then random words under several plane settings. Every
// response word is checked against a pinned value or an exact integer model.
// ----------------------------------------------------------------------------
module tb;

   localparam int CB = 12;
   localparam int FB = 8;
   localparam int OB = pt2pl_pkg::OUT_BITS;
   localparam int IB = pt2pl_pkg::CSR_INDEX_BITS;

   // index past the last point register
   localparam logic [IB-1:0] REG_PAST_END = 2'd3;

   typedef logic signed [CB-1:0]       coord_type;
   typedef logic [3*CB-1:0]            point_type;
   typedef logic signed [OB-1:0]       distance_type;

   typedef struct {
      distance_type dist_val;
      logic         degen;
   } distance_word_type;

   typedef struct {
      point_type    p1, p2, p3;
      coord_type    x, y, z;
      logic         pinned;
      distance_type dist_val;
      logic         degen;
   } table_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         start = 0;
   logic         busy;
   coord_type    req_query_x = '0, req_query_y = '0, req_query_z = '0;
   logic         rsp_strobe;
   distance_type rsp_signed_distance;
   logic         rsp_degenerate;
   logic         csr_write_enable = 0;
   logic [IB-1:0] csr_index = '0;
   point_type    csr_write_data = '0;

   // pinned expectation driven alongside the word
   logic         pin_en = 0;
   distance_type pin_dist = '0;
   logic         pin_degen = 0;

   point_type plane_p1 = '0, plane_p2 = '0, plane_p3 = '0;
   point_type cur_p1 = '0, cur_p2 = '0, cur_p3 = '0;
   distance_word_type expected_words[$];
   int mismatches = 0;
   int checked = 0;
   int degen_seen = 0;

   point_to_plane_distance_core uut (.*);

   initial forever #1 clock = ~clock;

   initial begin
      #2000000;
      $display("** point_to_plane_distance_core: FAILED **");
      $finish;
   end

   function automatic point_type pack_point(int x, int y, int z);
      coord_type cx, cy, cz;
      cx = coord_type'(x); cy = coord_type'(y); cz = coord_type'(z);
      return {cz, cy, cx};
   endfunction

   function automatic longint coord_of(point_type p, int idx);
      coord_type c;
      c = p[idx*CB +: CB];
      return longint'(c);
   endfunction

   function automatic distance_word_type plane_distance(point_type p1, point_type p2,
                                                        point_type p3, coord_type x,
                                                        coord_type y, coord_type z);
      distance_word_type w;
      longint ux, uy, uz, vx, vy, vz, a, b, c, num;
      logic [127:0] norm2, rhs, lhs, trial, q, cap, ma, mb, mc, mn;
      ux = coord_of(p2, 0) - coord_of(p1, 0);
      uy = coord_of(p2, 1) - coord_of(p1, 1);
      uz = coord_of(p2, 2) - coord_of(p1, 2);
      vx = coord_of(p3, 0) - coord_of(p1, 0);
      vy = coord_of(p3, 1) - coord_of(p1, 1);
      vz = coord_of(p3, 2) - coord_of(p1, 2);
      a = uy * vz - uz * vy;
      b = uz * vx - ux * vz;
      c = ux * vy - uy * vx;
      w.dist_val = '0;
      w.degen = 1'b0;
      if (a == 0 && b == 0 && c == 0) begin
         w.degen = 1'b1;
         return w;
      end
      num = a * (longint'(x) - coord_of(p1, 0)) + b * (longint'(y) - coord_of(p1, 1))
            + c * (longint'(z) - coord_of(p1, 2));
      ma = 128'((a < 0) ? -a : a);
      mb = 128'((b < 0) ? -b : b);
      mc = 128'((c < 0) ? -c : c);
      mn = 128'((num < 0) ? -num : num);
      norm2 = ma * ma + mb * mb + mc * mc;
      rhs = (mn * mn) << (2 * FB);
      cap = (num < 0) ? (128'd1 << (OB - 1)) : ((128'd1 << (OB - 1)) - 128'd1);
      q = '0;
      for (int bitn = OB - 1; bitn >= 0; bitn--) begin
         trial = q | (128'd1 << bitn);
         if (trial <= cap) begin
            lhs = trial * trial * norm2;
            if (lhs <= rhs) q = trial;
         end
      end
      w.dist_val = (num < 0) ? -q[OB-1:0] : q[OB-1:0];
      return w;
   endfunction

   // acceptance and response checking
   always @(posedge clock) begin
      distance_word_type w, got;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               pt2pl_pkg::REG_FIRST_POINT:  plane_p1 <= csr_write_data;
               pt2pl_pkg::REG_SECOND_POINT: plane_p2 <= csr_write_data;
               pt2pl_pkg::REG_THIRD_POINT:  plane_p3 <= csr_write_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (pin_en) begin
               w.dist_val = pin_dist;
               w.degen = pin_degen;
            end else begin
               w = plane_distance(plane_p1, plane_p2, plane_p3,
                                  req_query_x, req_query_y, req_query_z);
            end
            expected_words.push_back(w);
         end
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response word: dist=%0d degen=%0b",
                           rsp_signed_distance, rsp_degenerate);
            end else begin
               got = expected_words.pop_front();
               checked++;
               if (rsp_degenerate) degen_seen++;
               if (got.dist_val !== rsp_signed_distance || got.degen !== rsp_degenerate) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected dist=%0d degen=%0b, got dist=%0d degen=%0b",
                              got.dist_val, got.degen, rsp_signed_distance, rsp_degenerate);
               end
            end
         end
      end
   end

   task automatic drain();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [IB-1:0] idx, point_type data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_plane(point_type p1, point_type p2, point_type p3);
      start <= 1'b0;
      pin_en <= 1'b0;
      @(posedge clock);
      drain();
      repeat (35) @(posedge clock);
      write_reg(pt2pl_pkg::REG_FIRST_POINT, p1);
      write_reg(pt2pl_pkg::REG_SECOND_POINT, p2);
      write_reg(pt2pl_pkg::REG_THIRD_POINT, p3);
      cur_p1 = p1; cur_p2 = p2; cur_p3 = p3;
   endtask

   task automatic send(coord_type x, coord_type y, coord_type z, logic pinned,
                       distance_type d, logic dg);
      start <= 1'b1;
      req_query_x <= x;
      req_query_y <= y;
      req_query_z <= z;
      pin_en <= pinned;
      pin_dist <= d;
      pin_degen <= dg;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      pin_en <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic point_type rand_point();
      return point_type'({$urandom, $urandom});
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'(-2048);
         1: return coord_type'(2047);
         2: return coord_type'($urandom_range(0, 15) - 8);
         default: return coord_type'($urandom);
      endcase
   endfunction

   table_row_type dir_rows[$];

   initial begin
      point_type zp0, zp1, zp2, lo0, lo1, lo2, p1, p2, p3;
      int dx, dy, dz, bx, by, bz, k;
      table_row_type r;
      zp0 = pack_point(0, 0, 0);
      zp1 = pack_point(1, 0, 0);
      zp2 = pack_point(0, 1, 0);
      lo0 = pack_point(-2048, -2048, -2048);
      lo1 = pack_point(2047, -2048, -2048);
      lo2 = pack_point(-2048, 2047, -2048);
      // p1, p2, p3, x, y, z, pinned, dist, degen
      dir_rows = '{
         '{'0, '0, '0, 0, 0, 0, 1, 0, 1},
         '{'0, '0, '0, 2047, -2048, 5, 1, 0, 1},
         '{zp0, zp1, zp2, 0, 0, 2047, 1, 524032, 0},
         '{zp0, zp1, zp2, 0, 0, -2048, 1, -524288, 0},
         '{zp0, zp1, zp2, 2047, -2048, 0, 1, 0, 0},
         '{zp0, zp1, zp2, -2048, 2047, 1, 1, 256, 0},
         '{zp0, zp1, zp2, 5, 7, -1, 1, -256, 0},
         '{lo0, lo1, lo2, 0, 0, 2047, 1, 1048320, 0},
         '{lo0, lo1, lo2, 2047, 2047, -2048, 1, 0, 0},
         '{lo0, lo1, lo2, -2048, -2048, -2047, 1, 256, 0},
         '{pack_point(1, 1, 1), pack_point(2, 2, 2), pack_point(3, 3, 3),
           100, -7, 3, 1, 0, 1},
         '{pack_point(9, -4, 7), pack_point(9, -4, 7), pack_point(9, -4, 7),
           -2048, 2047, 0, 1, 0, 1},
         '{pack_point(3, 0, 0), pack_point(0, 4, 0), pack_point(0, 0, 5),
           3, 0, 0, 1, 0, 0},
         '{pack_point(3, 0, 0), pack_point(0, 4, 0), pack_point(0, 0, 5),
           0, 0, 0, 0, 0, 0},
         '{pack_point(3, 0, 0), pack_point(0, 4, 0), pack_point(0, 0, 5),
           2047, 2047, 2047, 0, 0, 0},
         '{pack_point(3, 0, 0), pack_point(0, 4, 0), pack_point(0, 0, 5),
           -2048, -2048, -2048, 0, 0, 0},
         '{lo1, lo0, pack_point(2047, 2047, 2047), -2048, 2047, 2047, 0, 0, 0},
         '{lo1, lo0, pack_point(2047, 2047, 2047), 2047, -2048, -2048, 0, 0, 0},
         '{pack_point(2047, -2048, 2047), pack_point(-2048, 2047, -2048),
           pack_point(2047, 2047, -2048), -2048, -2048, 2047, 0, 0, 0},
         '{pack_point(2047, -2048, 2047), pack_point(-2048, 2047, -2048),
           pack_point(2047, 2047, -2048), 1, -1, 0, 0, 0, 0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // index past the last point register is a no-op
      write_reg(REG_PAST_END, rand_point());

      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         if (i > 0 && (r.p1 != cur_p1 || r.p2 != cur_p2 || r.p3 != cur_p3))
            load_plane(r.p1, r.p2, r.p3);
         send(r.x, r.y, r.z, r.pinned, r.dist_val, r.degen);
      end

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin
               p1 = rand_point(); p2 = rand_point(); p3 = rand_point();
            end
            1: begin
               // collinear: p3 = p1 + k*(p2-p1)
               bx = $urandom_range(0, 200) - 100;
               by = $urandom_range(0, 200) - 100;
               bz = $urandom_range(0, 200) - 100;
               dx = $urandom_range(0, 40) - 20;
               dy = $urandom_range(0, 40) - 20;
               dz = $urandom_range(0, 40) - 20;
               k = $urandom_range(0, 6) - 3;
               p1 = pack_point(bx, by, bz);
               p2 = pack_point(bx + dx, by + dy, bz + dz);
               p3 = pack_point(bx + k * dx, by + k * dy, bz + k * dz);
            end
            2: begin
               p1 = pack_point(rand_coord(), rand_coord(), rand_coord());
               p2 = pack_point(rand_coord(), rand_coord(), rand_coord());
               p3 = pack_point(rand_coord(), rand_coord(), rand_coord());
            end
            default: begin
               p1 = pack_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                               $urandom_range(0, 8) - 4);
               p2 = pack_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                               $urandom_range(0, 8) - 4);
               p3 = pack_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                               $urandom_range(0, 8) - 4);
            end
         endcase
         load_plane(p1, p2, p3);
         for (int n = 0; n < 56; n++) begin
            if (ph < 6 && $urandom_range(0, 5) == 0)
               pause($urandom_range(1, 16));
            if (ph == 2 && n == 28) begin
               pause(1);
               drain();
            end
            send(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0, 1'b0);
         end
      end

      pause(1);
      drain();
      repeat (40) @(posedge clock);
      $display("checked %0d distance words (%0d degenerate) over %0d directed rows",
               checked, degen_seen, dir_rows.size());
      $display("and 8 random plane settings, %0d mismatches", mismatches);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("** point_to_plane_distance_core: PASSED **");
      else
         $display("** point_to_plane_distance_core: FAILED **");
      $finish;
   end

endmodule
